@@ design/cmp_pkg.sv @@
// Shared types, constants and scaling function of the converter measurement and protection block.
package cmp_pkg;

   localparam int ADC_W     = 12;
   localparam int VAL_W     = 32;
   localparam int LIMIT_W   = 31;
   localparam int TRIP_W    = 47;
   localparam int CSR_W     = 47;
   localparam int CSR_IDX_W = 3;
   localparam int FAULT_W   = 5;
   localparam int MAG_W     = 27;
   localparam int INJ_RAW_W = 18;
   localparam int ACC_W     = TRIP_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INDUCTOR_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CUR_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_VOLT_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_VOLT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_CURRENT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLOAD_LEVEL  = 3'd5;

   localparam int FAULT_OVERLOAD = 0;
   localparam int FAULT_INDUCTOR = 1;
   localparam int FAULT_OUT_CUR  = 2;
   localparam int FAULT_IN_VOLT  = 3;
   localparam int FAULT_OUT_VOLT = 4;

   localparam logic [LIMIT_W-1:0] RST_INDUCTOR_LIMIT  = 31'd524288;
   localparam logic [LIMIT_W-1:0] RST_OUT_CUR_LIMIT   = 31'd196608;
   localparam logic [LIMIT_W-1:0] RST_IN_VOLT_LIMIT   = 31'd5898240;
   localparam logic [LIMIT_W-1:0] RST_OUT_VOLT_LIMIT  = 31'd6553600;
   localparam logic [LIMIT_W-1:0] RST_NOMINAL_CURRENT = 31'd327680;
   localparam logic [TRIP_W-1:0]  RST_OVERLOAD_LEVEL  = 47'd13107200000;

   // Q32 scale magnitudes and Q16 shifts
   localparam logic [LIMIT_W-1:0] SC_INJ      = 31'd3461146;
   localparam logic [LIMIT_W-1:0] SC_U2_MAG   = 31'd8076007;
   localparam logic [LIMIT_W-1:0] SC_IL       = 31'd8501458;
   localparam logic [LIMIT_W-1:0] SC_TEMP     = 31'd1384458323;
   localparam logic [LIMIT_W-1:0] SC_U1       = 31'd107296873;
   localparam logic [LIMIT_W-1:0] SC_IN       = 31'd4250729;
   localparam logic signed [VAL_W-1:0] SH_U2   = 32'sd6579814;
   localparam logic signed [VAL_W-1:0] SH_TEMP = -32'sd18284544;

   typedef struct packed {
      logic [ADC_W-1:0] adc_injection;
      logic [ADC_W-1:0] adc_output_voltage;
      logic [ADC_W-1:0] adc_inductor_current;
      logic [ADC_W-1:0] adc_temperature;
      logic [ADC_W-1:0] adc_input_voltage;
      logic [ADC_W-1:0] adc_output_current;
      logic             start_calibration;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] injection_value;
      logic signed [VAL_W-1:0] output_voltage;
      logic signed [VAL_W-1:0] inductor_current;
      logic signed [VAL_W-1:0] temperature;
      logic signed [VAL_W-1:0] input_voltage;
      logic signed [VAL_W-1:0] output_current;
      logic [FAULT_W-1:0]      fault_flags;
      logic                    pwm_enabled;
      logic                    calibrating;
   } rsp_type;

   typedef struct packed {
      logic [INJ_RAW_W-1:0]    inj_raw;
      logic signed [VAL_W-1:0] output_voltage;
      logic signed [VAL_W-1:0] inductor_current;
      logic signed [VAL_W-1:0] temperature;
      logic signed [VAL_W-1:0] input_voltage;
      logic signed [VAL_W-1:0] output_current;
      logic                    start_calibration;
   } scaled_type;

   // round(adc * mag / 2^16), half up on the magnitude
   function automatic logic [MAG_W-1:0] scale_mag(logic [ADC_W-1:0] adc,
                                                  logic [LIMIT_W-1:0] mag);
      logic [ADC_W+LIMIT_W-1:0] prod;
      prod = {{LIMIT_W{1'b0}}, adc} * {{ADC_W{1'b0}}, mag}
             + (ADC_W+LIMIT_W)'(32768);
      return prod[ADC_W+LIMIT_W-1:16];
   endfunction

endpackage

@@ design/cmp_scale.sv @@
// Affine scaling of the six raw ADC channels to Q15.16 values.
module cmp_scale (
   input  cmp_pkg::req_type    req,
   output cmp_pkg::scaled_type scaled
);

   localparam int PAD_W = cmp_pkg::VAL_W - cmp_pkg::MAG_W;

   logic [cmp_pkg::MAG_W-1:0] inj_mag;
   logic [cmp_pkg::MAG_W-1:0] u2_mag;
   logic [cmp_pkg::MAG_W-1:0] il_mag;
   logic [cmp_pkg::MAG_W-1:0] temp_mag;
   logic [cmp_pkg::MAG_W-1:0] u1_mag;
   logic [cmp_pkg::MAG_W-1:0] icur_mag;

   always_comb begin
      inj_mag  = cmp_pkg::scale_mag(req.adc_injection, cmp_pkg::SC_INJ);
      u2_mag   = cmp_pkg::scale_mag(req.adc_output_voltage, cmp_pkg::SC_U2_MAG);
      il_mag   = cmp_pkg::scale_mag(req.adc_inductor_current, cmp_pkg::SC_IL);
      temp_mag = cmp_pkg::scale_mag(req.adc_temperature, cmp_pkg::SC_TEMP);
      u1_mag   = cmp_pkg::scale_mag(req.adc_input_voltage, cmp_pkg::SC_U1);
      icur_mag = cmp_pkg::scale_mag(req.adc_output_current, cmp_pkg::SC_IN);

      scaled.inj_raw           = inj_mag[cmp_pkg::INJ_RAW_W-1:0];
      scaled.output_voltage    = cmp_pkg::SH_U2 - $signed({{PAD_W{1'b0}}, u2_mag});
      scaled.inductor_current  = $signed({{PAD_W{1'b0}}, il_mag});
      scaled.temperature       = $signed({{PAD_W{1'b0}}, temp_mag}) + cmp_pkg::SH_TEMP;
      scaled.input_voltage     = $signed({{PAD_W{1'b0}}, u1_mag});
      scaled.output_current    = $signed({{PAD_W{1'b0}}, icur_mag});
      scaled.start_calibration = req.start_calibration;
   end

endmodule

@@ design/cmp_div.sv @@
// Division of the calibration sum by a constant, by reciprocal multiplication.
module cmp_div #(
   parameter int DIVISOR = 1024,
   parameter int NUM_W   = 28,
   parameter int QUO_W   = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   output logic             busy,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
   localparam int RECIP_W = NUM_W + 1;
   localparam int PROD_W  = NUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] prod;

   // floor(n / d) = (n * ceil(2^SHIFT / d)) >> SHIFT for every NUM_W-bit n
   always_comb begin
      prod    = {{RECIP_W{1'b0}}, num_ff} * {{NUM_W{1'b0}}, RECIP};
      busy_in = start;
      done_in = busy_ff;
      num_in  = start ? numerator : num_ff;
      quo_in  = busy_ff ? prod[SHIFT +: QUO_W] : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/converter_measure_and_protect.sv @@
// Top level: ADC scaling, limit trips, overload integrator and offset calibration.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | cmp_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_ready   | cmp_pkg::rsp_type
//   csr     | in        | csr_write_enable      | csr_index, csr_data
//
// Three stages (input register, scaled register, result register); one transaction per cycle
// sustained while the result is taken and no offset division is in progress.
// The sample that ends a calibration starts the divider; the result stage then
// holds while the divider works, until the offset is set.
// Reset clears faults, integrator, calibration and offset and sets PWM enable.
// A stalled result holds the result stage; earlier stages keep filling until full.
module converter_measure_and_protect #(
   parameter int CAL_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  cmp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output cmp_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [cmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmp_pkg::CSR_W-1:0]       csr_data
);

   localparam int CNT_W = $clog2(CAL_COUNT + 1);
   localparam int SUM_W = cmp_pkg::INJ_RAW_W + $clog2(CAL_COUNT);
   localparam int VW    = cmp_pkg::VAL_W;
   localparam int LW    = cmp_pkg::LIMIT_W;
   localparam int TW    = cmp_pkg::TRIP_W;
   localparam int AW    = cmp_pkg::ACC_W;

   logic [LW-1:0] il_limit_ff, ocur_limit_ff, u1_limit_ff, u2_limit_ff, nominal_ff;
   logic [TW-1:0] trip_level_ff;

   logic                v1_ff, v1_in;
   logic                v2_ff, v2_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cmp_pkg::req_type    req_ff;
   cmp_pkg::scaled_type scaled;
   cmp_pkg::scaled_type s2_ff;
   cmp_pkg::rsp_type    rsp_ff, rsp_in;

   logic                   s2_load, s3_load, req_take;
   logic [cmp_pkg::FAULT_W-1:0] faults_ff, faults_in;
   logic                   pwm_ff, pwm_in;
   logic [TW-1:0]          integ_ff, integ_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in, cnt_eff;
   logic [SUM_W-1:0]       sum_ff, sum_in, sum_eff;
   logic signed [VW-1:0]   offset_ff, offset_in;
   logic signed [AW-1:0]   acc;
   logic                   div_start, div_busy, div_done;
   logic [SUM_W-1:0]       div_num;
   logic [cmp_pkg::INJ_RAW_W-1:0] div_quo;

   cmp_scale u_scale (
      .req    (req_ff),
      .scaled (scaled)
   );

   cmp_div #(
      .DIVISOR (CAL_COUNT),
      .NUM_W   (SUM_W),
      .QUO_W   (cmp_pkg::INJ_RAW_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo)
   );

   always_comb begin
      s3_load      = v2_ff && (!rsp_valid_ff || rsp_ready) && !div_busy && !div_done;
      s2_load      = v1_ff && (!v2_ff || s3_load);
      req_ready    = !v1_ff || s2_load;
      req_take     = req_valid && req_ready;
      v1_in        = req_take ? 1'b1 : (s2_load ? 1'b0 : v1_ff);
      v2_in        = s2_load ? 1'b1 : (s3_load ? 1'b0 : v2_ff);
      rsp_valid_in = s3_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      faults_in = faults_ff;
      if (s2_ff.inductor_current > $signed({1'b0, il_limit_ff}))
         faults_in[cmp_pkg::FAULT_INDUCTOR] = 1'b1;
      if (s2_ff.output_current > $signed({1'b0, ocur_limit_ff}))
         faults_in[cmp_pkg::FAULT_OUT_CUR] = 1'b1;
      if (s2_ff.input_voltage > $signed({1'b0, u1_limit_ff}))
         faults_in[cmp_pkg::FAULT_IN_VOLT] = 1'b1;
      if (s2_ff.output_voltage > $signed({1'b0, u2_limit_ff}))
         faults_in[cmp_pkg::FAULT_OUT_VOLT] = 1'b1;

      acc = $signed({2'b00, integ_ff})
            + $signed({{(AW-VW){s2_ff.inductor_current[VW-1]}}, s2_ff.inductor_current})
            - $signed({{(AW-LW){1'b0}}, nominal_ff});
      if (acc < 0) begin
         integ_in = '0;
      end else if (acc > $signed({2'b00, trip_level_ff})) begin
         integ_in = '0;
         faults_in[cmp_pkg::FAULT_OVERLOAD] = 1'b1;
      end else begin
         integ_in = acc[TW-1:0];
      end
      pwm_in = pwm_ff && (faults_in == '0);

      cnt_eff   = s2_ff.start_calibration ? CNT_W'(CAL_COUNT) : cnt_ff;
      sum_eff   = s2_ff.start_calibration ? '0 : sum_ff;
      offset_in = s2_ff.start_calibration ? '0 : offset_ff;
      cnt_in    = cnt_eff;
      sum_in    = sum_eff;
      div_start = 1'b0;
      if (cnt_eff != '0) begin
         sum_in    = sum_eff + SUM_W'(s2_ff.inj_raw);
         cnt_in    = cnt_eff - CNT_W'(1);
         div_start = s3_load && (cnt_eff == CNT_W'(1));
      end
      div_num = sum_in + SUM_W'(CAL_COUNT / 2);

      rsp_in.injection_value  = $signed({{(VW-cmp_pkg::INJ_RAW_W){1'b0}}, s2_ff.inj_raw})
                                + offset_ff;
      rsp_in.output_voltage   = s2_ff.output_voltage;
      rsp_in.inductor_current = s2_ff.inductor_current;
      rsp_in.temperature      = s2_ff.temperature;
      rsp_in.input_voltage    = s2_ff.input_voltage;
      rsp_in.output_current   = s2_ff.output_current;
      rsp_in.fault_flags      = faults_in;
      rsp_in.pwm_enabled      = pwm_in;
      rsp_in.calibrating      = cnt_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         il_limit_ff   <= cmp_pkg::RST_INDUCTOR_LIMIT;
         ocur_limit_ff <= cmp_pkg::RST_OUT_CUR_LIMIT;
         u1_limit_ff   <= cmp_pkg::RST_IN_VOLT_LIMIT;
         u2_limit_ff   <= cmp_pkg::RST_OUT_VOLT_LIMIT;
         nominal_ff    <= cmp_pkg::RST_NOMINAL_CURRENT;
         trip_level_ff <= cmp_pkg::RST_OVERLOAD_LEVEL;
      end else if (csr_write_enable) begin
         case (csr_index)
            cmp_pkg::CSR_INDUCTOR_LIMIT:  il_limit_ff   <= csr_data[LW-1:0];
            cmp_pkg::CSR_OUT_CUR_LIMIT:   ocur_limit_ff <= csr_data[LW-1:0];
            cmp_pkg::CSR_IN_VOLT_LIMIT:   u1_limit_ff   <= csr_data[LW-1:0];
            cmp_pkg::CSR_OUT_VOLT_LIMIT:  u2_limit_ff   <= csr_data[LW-1:0];
            cmp_pkg::CSR_NOMINAL_CURRENT: nominal_ff    <= csr_data[LW-1:0];
            cmp_pkg::CSR_OVERLOAD_LEVEL:  trip_level_ff <= csr_data[TW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         faults_ff    <= '0;
         pwm_ff       <= 1'b1;
         integ_ff     <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         offset_ff    <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s3_load) begin
            faults_ff <= faults_in;
            pwm_ff    <= pwm_in;
            integ_ff  <= integ_in;
            cnt_ff    <= cnt_in;
            sum_ff    <= sum_in;
            offset_ff <= offset_in;
         end else if (div_done) begin
            offset_ff <= -$signed({{(VW-cmp_pkg::INJ_RAW_W){1'b0}}, div_quo});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         req_ff <= req_data;
      if (s2_load)
         s2_ff <= scaled;
      if (s3_load)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/cmp_check.sv @@
// Port-level checker for the measurement and protection block, with its bind.
module cmp_check (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cmp_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   a_pwm_matches_faults: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pwm_enabled == (rsp_data.fault_flags == '0)))
      else $error("pwm enable disagrees with fault flags");

   a_faults_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid && $past(rsp_valid)
      |-> (($past(rsp_data.fault_flags) & ~rsp_data.fault_flags) == '0))
      else $error("latched fault bit cleared without reset");

   a_pwm_stays_off: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid && $past(rsp_valid) && !$past(rsp_data.pwm_enabled)
      |-> !rsp_data.pwm_enabled)
      else $error("pwm enable returned without reset");

endmodule

bind converter_measure_and_protect cmp_check u_cmp_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
